@@ src/fpw_pkg.sv @@
// fpw_pkg: field widths, register indexes, reset values and arithmetic constants
// for the fuel pulse-width pipeline; used by fpw_div and fuel_pulse_width_calc
`default_nettype none
package fpw_pkg;

  // field widths
  localparam int PRES_W   = 16;
  localparam int TEMP_W   = 12;
  localparam int VE_W     = 12;
  localparam int LAM_W    = 13;
  localparam int DEAD_W   = 16;
  localparam int PW_W     = 22;
  localparam int AIR_W    = 24;
  localparam int FUEL_W   = 22;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 21;
  localparam int CYL_W      = 17;
  localparam int AIRD_W     = 20;
  localparam int FUELD_W    = 21;
  localparam int STOICH_W   = 16;
  localparam int INJ_W      = 17;
  localparam int PULSES_W   = 5;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CYL_VOL  = 3'd0,
    REG_AIR_DENS = 3'd1,
    REG_FUEL_DENS = 3'd2,
    REG_STOICH   = 3'd3,
    REG_INJ_FLOW = 3'd4,
    REG_PULSES   = 3'd5
  } cfg_reg_t;

  localparam logic [CYL_W-1:0]    RST_CYL_VOL   = 17'd50000;
  localparam logic [AIRD_W-1:0]   RST_AIR_DENS  = 20'd127540;
  localparam logic [FUELD_W-1:0]  RST_FUEL_DENS = 21'd755000;
  localparam logic [STOICH_W-1:0] RST_STOICH    = 16'd14700;
  localparam logic [INJ_W-1:0]    RST_INJ_FLOW  = 17'd3000;
  localparam logic [PULSES_W-1:0] RST_PULSES    = 5'd1;

  // arithmetic constants
  localparam logic [15:0] K_ABS_ZERO   = 16'd27315;        // 0 C in 0.01 K
  localparam logic [36:0] K_DEN_SCALE  = 37'd100000000000;  // air mass unit scale
  localparam logic [29:0] K_GIGA       = 30'd1000000000;
  localparam logic [9:0]  K_PW_SCALE   = 10'd600;
  localparam logic [40:0] VF_CAP       = 41'h10000000000;  // 2^40 internal ceiling
  localparam logic [AIR_W-1:0]  AIR_MAX  = 24'hffffff;
  localparam logic [FUEL_W-1:0] FUEL_MAX = 22'h3fffff;
  localparam logic [PW_W-1:0]   PW_MAX   = 22'h3fffff;

  // divider geometry: quotient bits, divisor bits, sideband bits
  localparam int DIV1_QW = 31;
  localparam int DIV1_DW = 53;
  localparam int DIV1_SW = 41;
  localparam int DIV2_QW = 41;
  localparam int DIV2_DW = 51;
  localparam int DIV2_SW = 42;
  localparam int DIV3_QW = 22;
  localparam int DIV3_DW = 22;
  localparam int DIV3_SW = 64;

endpackage
`default_nettype wire

@@ src/fpw_div.sv @@
// fpw_div: pipelined restoring divider, one quotient bit per stage, with sideband
// depends on fpw_pkg for default geometry
`default_nettype none
module fpw_div #(
  parameter int QW = fpw_pkg::DIV1_QW,
  parameter int DW = fpw_pkg::DIV1_DW,
  parameter int SW = fpw_pkg::DIV1_SW
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [DW-1:0] in_rem,
  input  logic [QW-1:0] in_low,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [QW-1:0] out_quo,
  output logic [SW-1:0] out_side
);

  logic [QW-1:0] valid_r;
  logic [DW-1:0] rem_r  [QW];
  logic [QW-1:0] low_r  [QW];
  logic [QW-1:0] quo_r  [QW];
  logic [DW-1:0] den_r  [QW];
  logic [SW-1:0] side_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic          src_valid;
    logic [DW-1:0] src_rem;
    logic [DW-1:0] src_den;
    logic [QW-1:0] src_low;
    logic [QW-1:0] src_quo;
    logic [SW-1:0] src_side;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;
    logic [QW-1:0] quo_nxt;
    logic [QW-1:0] low_nxt;

    if (k == 0) begin : g_first
      assign src_valid = in_valid;
      assign src_rem   = in_rem;
      assign src_den   = in_den;
      assign src_low   = in_low;
      assign src_quo   = '0;
      assign src_side  = in_side;
    end else begin : g_next
      assign src_valid = valid_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_den   = den_r[k-1];
      assign src_low   = low_r[k-1];
      assign src_quo   = quo_r[k-1];
      assign src_side  = side_r[k-1];
    end

    // shift in the next numerator bit and try a subtract
    assign trial   = {src_rem, src_low[QW-1]};
    assign diff    = trial - {1'b0, src_den};
    assign ge      = trial >= {1'b0, src_den};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
    assign quo_nxt = {src_quo[QW-2:0], ge};
    assign low_nxt = {src_low[QW-2:0], 1'b0};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[k] <= 1'b0;
      end else if (en) begin
        valid_r[k] <= src_valid;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        low_r[k]  <= low_nxt;
        quo_r[k]  <= quo_nxt;
        den_r[k]  <= src_den;
        side_r[k] <= src_side;
      end
    end
  end

  assign out_valid = valid_r[QW-1];
  assign out_quo   = quo_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule
`default_nettype wire

@@ src/fuel_pulse_width_calc.sv @@
// fuel_pulse_width_calc: speed-density injector pulse-width pipeline top level
// depends on fpw_pkg and fpw_div (three instances)
//
// Usage: the in_ channel takes one item per cycle while in_ready is high
// (valid/ready), carrying pressures, temperatures, VE, lambda and dead time;
// the out_ channel returns one result item per input item, in order: pulse
// width, air mass, fuel volume and a saturation flag. The cfg_ channel writes
// the six calibration registers by index; cfg_ready is always high and writes
// beyond index five are dropped. Registers are only to be changed while no item
// is in flight. From acceptance to out_valid an item passes four multiply stages,
// a 31-stage air-mass divider, four fuel-divisor stages, a 41-stage fuel
// divider, three stages for the pulse divisor and a 22-stage pulse divider,
// then the output register. Throughput is one item per cycle while the pipe
// is not frozen, set by the one-bit-per-stage restoring dividers.
// Reset loads the calibration defaults and empties the pipeline. When the
// receiver stalls the finished item waits in the output register; the pipe
// keeps moving while its last stage is empty or can drain, freezes otherwise,
// so in_ready drops whenever the last divider stage holds an item that the
// output register cannot take, even if earlier stages still have bubbles.
`default_nettype none
module fuel_pulse_width_calc (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [fpw_pkg::PRES_W-1:0]        in_manifold_pressure,
  input  logic [fpw_pkg::PRES_W-1:0]        in_ambient_pressure,
  input  logic signed [fpw_pkg::TEMP_W-1:0] in_intake_temp,
  input  logic signed [fpw_pkg::TEMP_W-1:0] in_fuel_temp,
  input  logic [fpw_pkg::VE_W-1:0]          in_vol_efficiency,
  input  logic [fpw_pkg::LAM_W-1:0]         in_target_lambda,
  input  logic [fpw_pkg::DEAD_W-1:0]        in_dead_time,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fpw_pkg::PW_W-1:0]          out_pulse_width,
  output logic [fpw_pkg::AIR_W-1:0]         out_air_mass,
  output logic [fpw_pkg::FUEL_W-1:0]        out_fuel_volume,
  output logic                              out_saturated,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fpw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fpw_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fpw_pkg::*;

  // calibration registers
  logic [CYL_W-1:0]    cyl_vol_r;
  logic [AIRD_W-1:0]   air_dens_r;
  logic [FUELD_W-1:0]  fuel_dens_r;
  logic [STOICH_W-1:0] stoich_r;
  logic [INJ_W-1:0]    inj_flow_r;
  logic [PULSES_W-1:0] pulses_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyl_vol_r   <= RST_CYL_VOL;
      air_dens_r  <= RST_AIR_DENS;
      fuel_dens_r <= RST_FUEL_DENS;
      stoich_r    <= RST_STOICH;
      inj_flow_r  <= RST_INJ_FLOW;
      pulses_r    <= RST_PULSES;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_CYL_VOL:   cyl_vol_r   <= cfg_data[CYL_W-1:0];
        REG_AIR_DENS:  air_dens_r  <= cfg_data[AIRD_W-1:0];
        REG_FUEL_DENS: fuel_dens_r <= cfg_data[FUELD_W-1:0];
        REG_STOICH:    stoich_r    <= cfg_data[STOICH_W-1:0];
        REG_INJ_FLOW:  inj_flow_r  <= cfg_data[INJ_W-1:0];
        REG_PULSES:    pulses_r    <= cfg_data[PULSES_W-1:0];
        default: ;
      endcase
    end
  end

  // zero divisors count as one
  logic [STOICH_W-1:0] stoich_nz;
  logic [INJ_W-1:0]    inj_nz;
  logic [PULSES_W-1:0] pulses_nz;
  assign stoich_nz = (stoich_r == '0) ? STOICH_W'(1) : stoich_r;
  assign inj_nz    = (inj_flow_r == '0) ? INJ_W'(1) : inj_flow_r;
  assign pulses_nz = (pulses_r == '0) ? PULSES_W'(1) : pulses_r;

  // pipeline advance: moves while the last divider stage can drain
  logic d3_valid;
  logic out_valid_r;
  logic out_free;
  logic adv;
  assign out_free = !out_valid_r || out_ready;
  assign adv      = !d3_valid || out_free;
  assign in_ready = adv;

  // ambient pressure cancels out of the air mass, so it is not used
  logic unused_ambient;
  assign unused_ambient = ^in_ambient_pressure;

  // stage a1: VE times pressure, absolute intake temperature
  logic signed [17:0] tk_s;
  assign tk_s = 18'(in_intake_temp) * 18'sd10 + 18'sd27315;

  logic               a1_valid_r;
  logic [27:0]        a1_vp_r;
  logic [15:0]        a1_tk_r;
  logic [TEMP_W-1:0]  a1_tf_r;
  logic [LAM_W-1:0]   a1_lam_r;
  logic [DEAD_W-1:0]  a1_dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a1_valid_r <= 1'b0;
    end else if (adv) begin
      a1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a1_vp_r   <= 28'(in_vol_efficiency) * 28'(in_manifold_pressure);
      a1_tk_r   <= tk_s[15:0];
      a1_tf_r   <= in_fuel_temp;
      a1_lam_r  <= in_target_lambda;
      a1_dead_r <= in_dead_time;
    end
  end

  // stage a2: times cylinder volume, scaled temperature divisor
  logic               a2_valid_r;
  logic [44:0]        a2_vpc_r;
  logic [52:0]        a2_d1_r;
  logic [TEMP_W-1:0]  a2_tf_r;
  logic [LAM_W-1:0]   a2_lam_r;
  logic [DEAD_W-1:0]  a2_dead_r;

  // stage a3: times air density
  logic               a3_valid_r;
  logic [64:0]        a3_x_r;
  logic [52:0]        a3_d1_r;
  logic [TEMP_W-1:0]  a3_tf_r;
  logic [LAM_W-1:0]   a3_lam_r;
  logic [DEAD_W-1:0]  a3_dead_r;

  // stage a4: times 273.15 K scale
  logic               a4_valid_r;
  logic [79:0]        a4_x_r;
  logic [52:0]        a4_d1_r;
  logic [TEMP_W-1:0]  a4_tf_r;
  logic [LAM_W-1:0]   a4_lam_r;
  logic [DEAD_W-1:0]  a4_dead_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a2_valid_r <= 1'b0;
      a3_valid_r <= 1'b0;
      a4_valid_r <= 1'b0;
    end else if (adv) begin
      a2_valid_r <= a1_valid_r;
      a3_valid_r <= a2_valid_r;
      a4_valid_r <= a3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a2_vpc_r  <= 45'(a1_vp_r) * 45'(cyl_vol_r);
      a2_d1_r   <= 53'(a1_tk_r) * 53'(K_DEN_SCALE);
      a2_tf_r   <= a1_tf_r;
      a2_lam_r  <= a1_lam_r;
      a2_dead_r <= a1_dead_r;
      a3_x_r    <= 65'(a2_vpc_r) * 65'(air_dens_r);
      a3_d1_r   <= a2_d1_r;
      a3_tf_r   <= a2_tf_r;
      a3_lam_r  <= a2_lam_r;
      a3_dead_r <= a2_dead_r;
      a4_x_r    <= 80'(a3_x_r) * 80'(K_ABS_ZERO);
      a4_d1_r   <= a3_d1_r;
      a4_tf_r   <= a3_tf_r;
      a4_lam_r  <= a3_lam_r;
      a4_dead_r <= a3_dead_r;
    end
  end

  // air-mass divider: quotient always below 2^31
  logic                d1o_valid;
  logic [DIV1_QW-1:0]  d1o_m;
  logic [DIV1_SW-1:0]  d1o_side;

  fpw_div #(
    .QW (DIV1_QW),
    .DW (DIV1_DW),
    .SW (DIV1_SW)
  ) u_div_air (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (a4_valid_r),
    .in_rem    (DIV1_DW'(a4_x_r[79:DIV1_QW])),
    .in_low    (a4_x_r[DIV1_QW-1:0]),
    .in_den    (a4_d1_r),
    .in_side   ({a4_tf_r, a4_lam_r, a4_dead_r}),
    .out_valid (d1o_valid),
    .out_quo   (d1o_m),
    .out_side  (d1o_side)
  );

  logic signed [TEMP_W-1:0] d1o_tf;
  logic [LAM_W-1:0]         d1o_lam;
  logic [DEAD_W-1:0]        d1o_dead;
  assign {d1o_tf, d1o_lam, d1o_dead} = d1o_side;

  // stage f1: clip air mass, scale by 1e9, temperature-corrected fuel density
  logic signed [23:0] rho_s;
  assign rho_s = $signed({3'b000, fuel_dens_r}) + 24'sd14250 - 24'sd95 * 24'(d1o_tf);

  logic              f1_valid_r;
  logic [AIR_W-1:0]  f1_air_r;
  logic              f1_sat_r;
  logic [60:0]       f1_m9_r;
  logic [21:0]       f1_rho_r;
  logic [LAM_W-1:0]  f1_lam_r;
  logic [DEAD_W-1:0] f1_dead_r;

  // stage f2: stoich times density, numerator times 4096
  logic              f2_valid_r;
  logic [AIR_W-1:0]  f2_air_r;
  logic              f2_sat_r;
  logic [72:0]       f2_n2_r;
  logic [37:0]       f2_sr_r;
  logic [LAM_W-1:0]  f2_lam_r;
  logic [DEAD_W-1:0] f2_dead_r;

  // stage f3: times lambda
  logic              f3_valid_r;
  logic [AIR_W-1:0]  f3_air_r;
  logic              f3_sat_r;
  logic [72:0]       f3_n2_r;
  logic [50:0]       f3_d2_r;
  logic [DEAD_W-1:0] f3_dead_r;

  // stage f4: quotient range check against the 41-bit fuel divider width
  logic               f4_valid_r;
  logic [AIR_W-1:0]   f4_air_r;
  logic               f4_sat_r;
  logic               f4_ovf_r;
  logic [DIV2_DW-1:0] f4_rem_r;
  logic [DIV2_QW-1:0] f4_low_r;
  logic [DIV2_DW-1:0] f4_d2_r;
  logic [DEAD_W-1:0]  f4_dead_r;

  logic [LAM_W-1:0]   lam_nz;
  logic [31:0]        n2_hi;
  logic               n2_ovf;
  logic               air_clip;
  assign lam_nz   = (f2_lam_r == '0) ? LAM_W'(1) : f2_lam_r;
  assign n2_hi    = f3_n2_r[72:DIV2_QW];
  assign n2_ovf   = DIV2_DW'(n2_hi) >= f3_d2_r;
  assign air_clip = |d1o_m[DIV1_QW-1:AIR_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
      f2_valid_r <= 1'b0;
      f3_valid_r <= 1'b0;
      f4_valid_r <= 1'b0;
    end else if (adv) begin
      f1_valid_r <= d1o_valid;
      f2_valid_r <= f1_valid_r;
      f3_valid_r <= f2_valid_r;
      f4_valid_r <= f3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_air_r  <= air_clip ? AIR_MAX : d1o_m[AIR_W-1:0];
      f1_sat_r  <= air_clip;
      f1_m9_r   <= 61'(d1o_m) * 61'(K_GIGA);
      f1_rho_r  <= (rho_s < 24'sd1) ? 22'd1 : rho_s[21:0];
      f1_lam_r  <= d1o_lam;
      f1_dead_r <= d1o_dead;

      f2_air_r  <= f1_air_r;
      f2_sat_r  <= f1_sat_r;
      f2_n2_r   <= {f1_m9_r, 12'd0};
      f2_sr_r   <= 38'(stoich_nz) * 38'(f1_rho_r);
      f2_lam_r  <= f1_lam_r;
      f2_dead_r <= f1_dead_r;

      f3_air_r  <= f2_air_r;
      f3_sat_r  <= f2_sat_r;
      f3_n2_r   <= f2_n2_r;
      f3_d2_r   <= 51'(f2_sr_r) * 51'(lam_nz);
      f3_dead_r <= f2_dead_r;

      f4_air_r  <= f3_air_r;
      f4_sat_r  <= f3_sat_r;
      f4_ovf_r  <= n2_ovf;
      f4_rem_r  <= n2_ovf ? '0 : DIV2_DW'(n2_hi);
      f4_low_r  <= f3_n2_r[DIV2_QW-1:0];
      f4_d2_r   <= f3_d2_r;
      f4_dead_r <= f3_dead_r;
    end
  end

  // fuel-volume divider
  logic                d2o_valid;
  logic [DIV2_QW-1:0]  d2o_q;
  logic [DIV2_SW-1:0]  d2o_side;

  fpw_div #(
    .QW (DIV2_QW),
    .DW (DIV2_DW),
    .SW (DIV2_SW)
  ) u_div_fuel (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (f4_valid_r),
    .in_rem    (f4_rem_r),
    .in_low    (f4_low_r),
    .in_den    (f4_d2_r),
    .in_side   ({f4_air_r, f4_sat_r, f4_ovf_r, f4_dead_r}),
    .out_valid (d2o_valid),
    .out_quo   (d2o_q),
    .out_side  (d2o_side)
  );

  logic [AIR_W-1:0]  d2o_air;
  logic              d2o_sat;
  logic              d2o_ovf;
  logic [DEAD_W-1:0] d2o_dead;
  assign {d2o_air, d2o_sat, d2o_ovf, d2o_dead} = d2o_side;

  // stage p1: cap fuel volume, clip output, pulse divisor
  logic [40:0] vf;
  logic        fuel_clip;
  assign vf        = (d2o_ovf || (d2o_q > VF_CAP)) ? VF_CAP : d2o_q;
  assign fuel_clip = vf > 41'(FUEL_MAX);

  logic               p1_valid_r;
  logic [40:0]        p1_vf_r;
  logic [AIR_W-1:0]   p1_air_r;
  logic [FUEL_W-1:0]  p1_fuel_r;
  logic               p1_sat_r;
  logic [DIV3_DW-1:0] p1_d3_r;
  logic [DEAD_W-1:0]  p1_dead_r;

  // stage p2: times 600
  logic               p2_valid_r;
  logic [50:0]        p2_n3_r;
  logic [AIR_W-1:0]   p2_air_r;
  logic [FUEL_W-1:0]  p2_fuel_r;
  logic               p2_sat_r;
  logic [DIV3_DW-1:0] p2_d3_r;
  logic [DEAD_W-1:0]  p2_dead_r;

  // stage p3: quotient range check against the pulse width field
  logic               p3_valid_r;
  logic [DIV3_DW-1:0] p3_rem_r;
  logic [DIV3_QW-1:0] p3_low_r;
  logic [DIV3_DW-1:0] p3_d3_r;
  logic [AIR_W-1:0]   p3_air_r;
  logic [FUEL_W-1:0]  p3_fuel_r;
  logic               p3_sat_r;
  logic               p3_ovf_r;
  logic [DEAD_W-1:0]  p3_dead_r;

  logic [28:0] n3_hi;
  logic        n3_ovf;
  assign n3_hi  = p2_n3_r[50:DIV3_QW];
  assign n3_ovf = n3_hi >= 29'(p2_d3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r <= 1'b0;
      p2_valid_r <= 1'b0;
      p3_valid_r <= 1'b0;
    end else if (adv) begin
      p1_valid_r <= d2o_valid;
      p2_valid_r <= p1_valid_r;
      p3_valid_r <= p2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p1_vf_r   <= vf;
      p1_air_r  <= d2o_air;
      p1_fuel_r <= fuel_clip ? FUEL_MAX : vf[FUEL_W-1:0];
      p1_sat_r  <= d2o_sat || fuel_clip;
      p1_d3_r   <= DIV3_DW'(inj_nz) * DIV3_DW'(pulses_nz);
      p1_dead_r <= d2o_dead;

      p2_n3_r   <= 51'(p1_vf_r) * 51'(K_PW_SCALE);
      p2_air_r  <= p1_air_r;
      p2_fuel_r <= p1_fuel_r;
      p2_sat_r  <= p1_sat_r;
      p2_d3_r   <= p1_d3_r;
      p2_dead_r <= p1_dead_r;

      p3_rem_r  <= n3_ovf ? '0 : n3_hi[DIV3_DW-1:0];
      p3_low_r  <= p2_n3_r[DIV3_QW-1:0];
      p3_d3_r   <= p2_d3_r;
      p3_air_r  <= p2_air_r;
      p3_fuel_r <= p2_fuel_r;
      p3_sat_r  <= p2_sat_r;
      p3_ovf_r  <= n3_ovf;
      p3_dead_r <= p2_dead_r;
    end
  end

  // pulse-width divider
  logic [DIV3_QW-1:0]  d3o_q;
  logic [DIV3_SW-1:0]  d3o_side;

  fpw_div #(
    .QW (DIV3_QW),
    .DW (DIV3_DW),
    .SW (DIV3_SW)
  ) u_div_pw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (p3_valid_r),
    .in_rem    (p3_rem_r),
    .in_low    (p3_low_r),
    .in_den    (p3_d3_r),
    .in_side   ({p3_air_r, p3_fuel_r, p3_sat_r, p3_ovf_r, p3_dead_r}),
    .out_valid (d3_valid),
    .out_quo   (d3o_q),
    .out_side  (d3o_side)
  );

  logic [AIR_W-1:0]  d3o_air;
  logic [FUEL_W-1:0] d3o_fuel;
  logic              d3o_sat;
  logic              d3o_ovf;
  logic [DEAD_W-1:0] d3o_dead;
  assign {d3o_air, d3o_fuel, d3o_sat, d3o_ovf, d3o_dead} = d3o_side;

  // dead time and final clip
  logic [PW_W:0] pw_sum;
  logic          pw_clip;
  assign pw_sum  = (PW_W + 1)'(d3o_q) + (PW_W + 1)'(d3o_dead);
  assign pw_clip = d3o_ovf || (pw_sum > (PW_W + 1)'(PW_MAX));

  // output register
  logic [PW_W-1:0]   out_pw_r;
  logic [AIR_W-1:0]  out_air_r;
  logic [FUEL_W-1:0] out_fuel_r;
  logic              out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= d3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_pw_r   <= pw_clip ? PW_MAX : pw_sum[PW_W-1:0];
      out_air_r  <= d3o_air;
      out_fuel_r <= d3o_fuel;
      out_sat_r  <= d3o_sat || pw_clip;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pulse_width = out_pw_r;
  assign out_air_mass    = out_air_r;
  assign out_fuel_volume = out_fuel_r;
  assign out_saturated   = out_sat_r;

endmodule
`default_nettype wire

@@ test/fuel_pulse_width_calc_tb.sv @@
// fuel_pulse_width_calc_tb: self-checking testbench for the injector pulse-width pipeline
// depends on fpw_pkg and the fuel_pulse_width_calc top level with its dividers
`default_nettype none
module fuel_pulse_width_calc_tb;
  import fpw_pkg::*;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 130;
  localparam int STALL_LIMIT = 5000;
  localparam int RAND_PER_PHASE = 300;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
  localparam logic [127:0] WIDE_CEIL = 128'(VF_CAP);

  typedef struct packed {
    logic [PRES_W-1:0]        manifold;
    logic [PRES_W-1:0]        ambient;
    logic signed [TEMP_W-1:0] air_temp;
    logic signed [TEMP_W-1:0] fuel_temp;
    logic [VE_W-1:0]          ve;
    logic [LAM_W-1:0]         lambda;
    logic [DEAD_W-1:0]        dead;
  } engine_item_t;

  typedef struct packed {
    logic [PW_W-1:0]   pw;
    logic [AIR_W-1:0]  air;
    logic [FUEL_W-1:0] fuel;
    logic              sat;
  } fuel_result_t;

  typedef struct {
    engine_item_t item;
    bit           typed;
    fuel_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  engine_item_t drv = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  fuel_result_t got;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // typed expectation travelling with the item being offered
  bit drv_typed = 1'b0;
  fuel_result_t drv_res = '0;

  // calibration copy kept by the predictor
  logic [CYL_W-1:0]    cal_cyl;
  logic [AIRD_W-1:0]   cal_aird;
  logic [FUELD_W-1:0]  cal_fueld;
  logic [STOICH_W-1:0] cal_stoich;
  logic [INJ_W-1:0]    cal_inj;
  logic [PULSES_W-1:0] cal_pulses;

  fuel_result_t pending_results[$];
  int mismatches = 0;
  int results_seen = 0;
  int items_sent = 0;
  int cfg_writes = 0;
  int stall_count = 0;
  bit hold_req = 1'b0;
  bit no_idle = 1'b0;

  always #1 clk = ~clk;

  fuel_pulse_width_calc i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_ready             (in_ready),
    .in_manifold_pressure (drv.manifold),
    .in_ambient_pressure  (drv.ambient),
    .in_intake_temp       (drv.air_temp),
    .in_fuel_temp         (drv.fuel_temp),
    .in_vol_efficiency    (drv.ve),
    .in_target_lambda     (drv.lambda),
    .in_dead_time         (drv.dead),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_pulse_width      (got.pw),
    .out_air_mass         (got.air),
    .out_fuel_volume      (got.fuel),
    .out_saturated        (got.sat),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  // speed-density pulse width from the current calibration
  function automatic fuel_result_t calc_pulse(engine_item_t it);
    fuel_result_t r;
    logic [127:0] num, den, air_q, vol_q, width;
    longint kelvin, rho;
    r = '0;
    kelvin = 10 * longint'(it.air_temp) + 27315;
    num = 128'(it.ve) * 128'(it.manifold) * 128'(cal_cyl) * 128'(cal_aird) * 128'(27315);
    den = 128'(K_DEN_SCALE) * 128'(kelvin);
    air_q = num / den;
    if (air_q > WIDE_CEIL) air_q = WIDE_CEIL;
    if (air_q > 128'(AIR_MAX)) begin
      r.air = AIR_MAX;
      r.sat = 1'b1;
    end else begin
      r.air = air_q[AIR_W-1:0];
    end
    // fuel density corrected for temperature, floored at one
    rho = longint'(cal_fueld) + 14250 - 95 * longint'(it.fuel_temp);
    if (rho < 1) rho = 1;
    num = air_q * 128'(4096) * 128'(K_GIGA);
    den = 128'((cal_stoich == 0) ? 1 : cal_stoich) * 128'(rho)
        * 128'((it.lambda == 0) ? 1 : it.lambda);
    vol_q = num / den;
    if (vol_q > WIDE_CEIL) vol_q = WIDE_CEIL;
    if (vol_q > 128'(FUEL_MAX)) begin
      r.fuel = FUEL_MAX;
      r.sat = 1'b1;
    end else begin
      r.fuel = vol_q[FUEL_W-1:0];
    end
    den = 128'((cal_inj == 0) ? 1 : cal_inj) * 128'((cal_pulses == 0) ? 1 : cal_pulses);
    width = vol_q * 128'(K_PW_SCALE) / den + 128'(it.dead);
    if (width > 128'(PW_MAX)) begin
      r.pw = PW_MAX;
      r.sat = 1'b1;
    end else begin
      r.pw = width[PW_W-1:0];
    end
    return r;
  endfunction

  // calibration copy, expectations and result checking
  always @(posedge clk) begin
    if (!rst_n) begin
      cal_cyl <= RST_CYL_VOL;
      cal_aird <= RST_AIR_DENS;
      cal_fueld <= RST_FUEL_DENS;
      cal_stoich <= RST_STOICH;
      cal_inj <= RST_INJ_FLOW;
      cal_pulses <= RST_PULSES;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CYL_VOL:   cal_cyl <= cfg_data[CYL_W-1:0];
          REG_AIR_DENS:  cal_aird <= cfg_data[AIRD_W-1:0];
          REG_FUEL_DENS: cal_fueld <= cfg_data[FUELD_W-1:0];
          REG_STOICH:    cal_stoich <= cfg_data[STOICH_W-1:0];
          REG_INJ_FLOW:  cal_inj <= cfg_data[INJ_W-1:0];
          REG_PULSES:    cal_pulses <= cfg_data[PULSES_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (drv_typed) pending_results.push_back(drv_res);
        else pending_results.push_back(calc_pulse(drv));
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result item %p", got);
        end else begin
          if (got !== pending_results[0]) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: pw %0d/%0d air %0d/%0d fuel %0d/%0d sat %0b/%0b",
                       pending_results[0].pw, got.pw, pending_results[0].air, got.air,
                       pending_results[0].fuel, got.fuel, pending_results[0].sat, got.sat);
          end
          void'(pending_results.pop_front());
        end
      end
    end
  end

  // watchdog on cycles with no handshake of any kind
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || !rst_n)
      stall_count <= 0;
    else
      stall_count <= stall_count + 1;
    if (stall_count >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic int idle_len();
    if (no_idle) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(0, 2);
    return $urandom_range(3, 30);
  endfunction

  // receiver: random back-pressure plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      out_ready <= no_idle ? 1'b1 : (idle_len() == 0);
    end
  end

  task automatic send_item(engine_item_t it, bit typed, fuel_result_t res);
    int g;
    drv <= it;
    drv_typed <= typed;
    drv_res <= res;
    in_valid <= 1'b1;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    items_sent++;
    g = idle_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // one write on the register port, with cfg_valid dropped again before returning
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(negedge clk);
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_writes++;
    @(posedge clk);
  endtask

  // wait until every item has come back, then let the pipe settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_all(int cyl, int aird, int fueld, int stoich, int inj, int pulses);
    write_reg(REG_CYL_VOL, CFG_DATA_W'(cyl));
    write_reg(REG_AIR_DENS, CFG_DATA_W'(aird));
    write_reg(REG_FUEL_DENS, CFG_DATA_W'(fueld));
    write_reg(REG_STOICH, CFG_DATA_W'(stoich));
    write_reg(REG_INJ_FLOW, CFG_DATA_W'(inj));
    write_reg(REG_PULSES, CFG_DATA_W'(pulses));
  endtask

  function automatic engine_item_t rand_item();
    engine_item_t it;
    it = engine_item_t'($bits(engine_item_t)'({$urandom, $urandom, $urandom, $urandom}));
    // mostly realistic engine conditions, the rest full-range noise
    if ($urandom_range(0, 3) != 0) begin
      it.manifold = PRES_W'($urandom_range(1000, 25000));
      it.air_temp = TEMP_W'($urandom_range(0, 1900) - 400);
      it.fuel_temp = TEMP_W'($urandom_range(0, 1900) - 400);
      it.ve = VE_W'($urandom_range(0, 1300));
      it.lambda = LAM_W'($urandom_range(2048, 8191));
      it.dead = DEAD_W'($urandom_range(0, 2000));
    end
    return it;
  endfunction

  task automatic random_phase(int count);
    for (int k = 0; k < count; k++) send_item(rand_item(), 1'b0, '0);
  endtask

  stim_row_t rows[$];
  engine_item_t it;

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table: zero air cases have results read off directly
    rows.push_back('{'{16'd0, 16'd0, 12'sd0, 12'sd0, 12'd0, 13'd4096, 16'd0}, 1, '0});
    rows.push_back('{'{16'hffff, 16'd1, 12'sd0, 12'sd0, 12'd0, 13'd4096, 16'hffff}, 1,
                     '{22'd65535, 24'd0, 22'd0, 1'b0}});
    rows.push_back('{'{16'd0, 16'hffff, -12'sd2048, 12'sd2047, 12'hfff, 13'd0, 16'd1234}, 1,
                     '{22'd1234, 24'd0, 22'd0, 1'b0}});
    rows.push_back('{'{16'd10000, 16'd10000, 12'sd200, 12'sd150, 12'd800, 13'd4096, 16'd900},
                     0, '0});
    rows.push_back('{'{16'd10000, 16'd0, 12'sd200, 12'sd150, 12'd800, 13'd4096, 16'd900},
                     0, '0});
    rows.push_back('{'{16'hffff, 16'hffff, -12'sd2048, -12'sd2048, 12'hfff, 13'd2048,
                       16'hffff}, 0, '0});
    rows.push_back('{'{16'hffff, 16'h8000, 12'sd2047, 12'sd2047, 12'hfff, 13'h1fff,
                       16'd0}, 0, '0});
    rows.push_back('{'{16'd5000, 16'd1, -12'sd400, -12'sd400, 12'd500, 13'd0, 16'd100},
                     0, '0});
    rows.push_back('{'{16'd20000, 16'd9000, 12'sd1500, 12'sd1500, 12'd2550, 13'd8191,
                       16'd65535}, 0, '0});
    rows.push_back('{'{16'd1, 16'd1, 12'sd0, 12'sd0, 12'd1, 13'd1, 16'd0}, 0, '0});
    foreach (rows[i]) send_item(rows[i].item, rows[i].typed, rows[i].res);
    drain();

    // lowest calibration; high fuel temperature drives density below one
    write_all(1, 1, 100000, 1000, 1, 1);
    it = '{16'hffff, 16'd1, 12'sd100, 12'sd2047, 12'hfff, 13'd2048, 16'd7};
    send_item(it, 1'b0, '0);
    it.fuel_temp = 12'sd1500;
    send_item(it, 1'b0, '0);
    random_phase(RAND_PER_PHASE);
    drain();

    // highest calibration, receiver held off so the pipe backs up
    write_all(100000, 1000000, 2000000, 50000, 100000, 16);
    hold_req = 1'b1;
    no_idle = 1'b1;
    random_phase(RAND_PER_PHASE);
    no_idle = 1'b0;
    drain();

    // zero registers act as one; unlisted indexes are dropped
    write_all(0, 0, 0, 0, 0, 0);
    write_reg(IDX_SPARE_LO, 21'h1fffff);
    write_reg(IDX_SPARE_HI, 21'h0);
    random_phase(RAND_PER_PHASE / 2);
    drain();

    // all-ones data truncated to register widths
    write_all(21'h1fffff, 21'h1fffff, 21'h1fffff, 21'h1fffff, 21'h1fffff, 21'h1fffff);
    random_phase(RAND_PER_PHASE / 2);
    drain();

    // back to typical calibration, then a few random settings
    write_all(50000, 127540, 755000, 14700, 3000, 1);
    random_phase(RAND_PER_PHASE);
    drain();
    for (int p = 0; p < 3; p++) begin
      write_all($urandom_range(1, 100000), $urandom_range(1, 1000000),
                $urandom_range(100000, 2000000), $urandom_range(1000, 50000),
                $urandom_range(1, 100000), $urandom_range(1, 16));
      random_phase(RAND_PER_PHASE / 2);
      drain();
    end

    $display("covered %0d items, %0d results and %0d register writes over nine settings",
             items_sent, results_seen, cfg_writes);
    $display("including a %0d-cycle receiver hold-off; %0d mismatches", HOLD_CYCLES,
             mismatches);
    if (mismatches == 0 && pending_results.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
`default_nettype wire
